### sv/hbg_pkg.sv
package hbg_pkg;

   localparam int MAX_MODULES_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int REP_W           = $clog2(MAX_RESULTS + 1);
   localparam int ID_W            = 16;
   localparam int TICK_W          = 16;
   localparam logic [TICK_W-1:0] TIMEOUT_DEF = TICK_W'(100);
   localparam logic [TICK_W-1:0] TICK_SAT    = {TICK_W{1'b1}};

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_REGISTER   = 2'd1,
      OP_UNREGISTER = 2'd2,
      OP_RESET_CNT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic {
      CSR_GUARD_ENABLE  = 1'b0,
      CSR_TIMEOUT_TICKS = 1'b1
   } csr_index_type;

   // one table slot
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] cnt;
   } entry_type;

   // what the head evaluator tells the sequencer about the slot passing by
   typedef struct packed {
      entry_type upd;
      logic      hit;
      logic      report;
   } head_result_type;

endpackage

### sv/heartbeat_guard_table_top.sv
// Channel | Dir | Handshake             | Word
// req     | in  | req_valid/req_ready   | req_op, req_module_id
// rsp     | out | rsp_valid/rsp_ready   | rsp_kind, rsp_status, rsp_module_id_res,
//         |     |                       | rsp_silent_ticks, rsp_last
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_wdata
//
// Every item except a disabled tick is accepted, then rotates the cell ring
// once past the head evaluator, then finishes.
// Output stalls freeze the ring.
// Synchronous active-high reset clears the entry count and the sequencer and
// sets the config registers to their defaults; cell contents are left undefined.
// A disabled tick is accepted and dropped, and gives no word.
module heartbeat_guard_table_top #(
   parameter int MAX_MODULES = hbg_pkg::MAX_MODULES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // item channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_op,
   input  logic [hbg_pkg::ID_W-1:0]   req_module_id,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic [1:0]                 rsp_status,
   output logic [hbg_pkg::ID_W-1:0]   rsp_module_id_res,
   output logic [hbg_pkg::TICK_W-1:0] rsp_silent_ticks,
   output logic                       rsp_last,
   // config channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [hbg_pkg::TICK_W-1:0] csr_wdata
);
   import hbg_pkg::*;

   localparam int STEP_W   = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
   localparam int CNT_W    = $clog2(MAX_MODULES + 1);
   // lookahead cell used while compacting after a removal
   localparam int NEXT_IDX = (MAX_MODULES > 1) ? 1 : 0;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_MODULES - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_MODULES);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_WALK  = 3'b010,
      S_FLUSH = 3'b100
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              found_ff, found_in;
   logic [REP_W-1:0]  nrep_ff, nrep_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              enable_ff;
   logic [TICK_W-1:0] timeout_ff;
   logic              rsp_valid_ff;

   // latched item and pending timeout report (payload)
   op_type            op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic [TICK_W-1:0] pend_cnt_ff, pend_cnt_in;

   // output register payload
   logic              kind_ff;
   logic [1:0]        status_ff;
   logic [ID_W-1:0]   oid_ff;
   logic [TICK_W-1:0] oticks_ff;
   logic              last_ff;

   logic              out_load;
   logic              out_kind;
   status_type        out_status;
   logic [ID_W-1:0]   out_id;
   logic [TICK_W-1:0] out_ticks;
   logic              out_last;
   logic              out_free;

   logic              shift_en;
   logic              push_needed;
   logic              in_range;
   logic              at_append;
   logic              full;
   entry_type         cell_q [MAX_MODULES];
   entry_type         tail_d;
   head_result_type   head_res;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_range  = CNT_W'(step_ff) < count_ff;
   assign at_append = CNT_W'(step_ff) == count_ff;
   assign full      = count_ff == CNT_FULL;

   // ring of slots: cell i takes cell i+1, the last cell takes the
   // evaluated head (or, while compacting, the head's successor)
   for (genvar gi = 0; gi < MAX_MODULES; gi++) begin : g_cell
      entry_type d_sel;
      if (gi == MAX_MODULES - 1) begin : g_tail
         assign d_sel = tail_d;
      end else begin : g_mid
         assign d_sel = cell_q[gi+1];
      end
      hbg_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d_in     (d_sel),
         .q        (cell_q[gi])
      );
   end

   hbg_head u_head (
      .head      (cell_q[0]),
      .op        (op_ff),
      .req_id    (id_ff),
      .in_range  (in_range),
      .at_append (at_append),
      .full      (full),
      .found     (found_ff),
      .rep_ok    (nrep_ff < REP_W'(MAX_RESULTS)),
      .threshold (timeout_ff),
      .res       (head_res)
   );

   // from the removed slot on, every slot takes its successor's entry
   assign tail_d = ((op_ff == OP_UNREGISTER) && (found_ff || head_res.hit))
                   ? cell_q[NEXT_IDX] : head_res.upd;

   assign push_needed = head_res.report && pend_valid_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      nrep_in       = nrep_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_cnt_in   = pend_cnt_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      shift_en      = 1'b0;
      out_load      = 1'b0;
      out_kind      = 1'b0;
      out_status    = ST_OK;
      out_id        = id_ff;
      out_ticks     = '0;
      out_last      = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = op_type'(req_op);
               id_in = req_module_id;
               if (!((op_type'(req_op) == OP_TICK) && !enable_ff)) begin
                  state_in      = S_WALK;
                  step_in       = '0;
                  found_in      = 1'b0;
                  nrep_in       = '0;
                  pend_valid_in = 1'b0;
               end
            end
         end
         S_WALK: begin
            // a new report pushes the held one out; hold the ring if blocked
            if (!push_needed || out_free) begin
               shift_en = 1'b1;
               step_in  = step_ff + STEP_W'(1);
               if (head_res.hit) begin
                  found_in = 1'b1;
               end
               if (head_res.report) begin
                  nrep_in       = nrep_ff + REP_W'(1);
                  pend_valid_in = 1'b1;
                  pend_id_in    = cell_q[0].id;
                  pend_cnt_in   = head_res.upd.cnt;
               end
               if (push_needed) begin
                  out_load  = 1'b1;
                  out_kind  = 1'b1;
                  out_id    = pend_id_ff;
                  out_ticks = pend_cnt_ff;
                  out_last  = 1'b0;
               end
               if (step_ff == STEP_LAST) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (op_ff == OP_TICK) begin
               if (!pend_valid_ff) begin
                  state_in = S_IDLE;
               end else if (out_free) begin
                  out_load  = 1'b1;
                  out_kind  = 1'b1;
                  out_id    = pend_id_ff;
                  out_ticks = pend_cnt_ff;
                  state_in  = S_IDLE;
               end
            end else if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               case (op_ff)
                  OP_REGISTER: begin
                     if (full) begin
                        out_status = ST_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_UNREGISTER: begin
                     if (found_ff) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        out_status = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (!found_ff) begin
                        out_status = ST_NOT_FOUND;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         nrep_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         enable_ff     <= 1'b0;
         timeout_ff    <= TIMEOUT_DEF;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
         nrep_ff       <= nrep_in;
         pend_valid_ff <= pend_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_GUARD_ENABLE:  enable_ff  <= csr_wdata[0];
               CSR_TIMEOUT_TICKS: timeout_ff <= csr_wdata;
               default:           enable_ff  <= enable_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      pend_id_ff  <= pend_id_in;
      pend_cnt_ff <= pend_cnt_in;
      if (out_load) begin
         kind_ff   <= out_kind;
         status_ff <= out_status;
         oid_ff    <= out_id;
         oticks_ff <= out_ticks;
         last_ff   <= out_last;
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_status        = status_ff;
   assign rsp_module_id_res = oid_ff;
   assign rsp_silent_ticks  = oticks_ff;
   assign rsp_last          = last_ff;

endmodule

### sv/hbg_cell.sv
// One table slot in the ring; takes its neighbor's entry on each shift.
module hbg_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  hbg_pkg::entry_type d_in,
   output hbg_pkg::entry_type q
);
   import hbg_pkg::*;

   entry_type store_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         store_ff <= d_in;
      end
   end

   assign q = store_ff;

endmodule

### sv/hbg_head.sv
// Evaluates the entry sitting in the head cell for the current operation.
module hbg_head (
   input  hbg_pkg::entry_type             head,
   input  hbg_pkg::op_type                op,
   input  logic [hbg_pkg::ID_W-1:0]       req_id,
   input  logic                           in_range,
   input  logic                           at_append,
   input  logic                           full,
   input  logic                           found,
   input  logic                           rep_ok,
   input  logic [hbg_pkg::TICK_W-1:0]     threshold,
   output hbg_pkg::head_result_type       res
);
   import hbg_pkg::*;

   logic              match;
   logic [TICK_W-1:0] cnt_inc;

   assign match   = in_range && !found && (head.id == req_id)
                    && (op inside {OP_UNREGISTER, OP_RESET_CNT});
   assign cnt_inc = (head.cnt == TICK_SAT) ? head.cnt : head.cnt + TICK_W'(1);

   always_comb begin
      res.upd    = head;
      res.hit    = match;
      res.report = 1'b0;
      case (op)
         OP_TICK: begin
            if (in_range) begin
               res.upd.cnt = cnt_inc;
               res.report  = rep_ok && (cnt_inc >= threshold);
            end
         end
         OP_REGISTER: begin
            if (at_append && !full) begin
               res.upd.id  = req_id;
               res.upd.cnt = '0;
            end
         end
         OP_RESET_CNT: begin
            if (match) begin
               res.upd.cnt = '0;
            end
         end
         default: begin
            res.upd = head;
         end
      endcase
   end

endmodule
